FILE: rtl/core/lsnr_pkg.sv
// Shared constants and types for the light sensor nibble responder.
package lsnr_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int OFFSET_BITS = 9;
    localparam int NIBBLE_BITS = 4;
    localparam int SERVO_BITS  = 2;
    localparam int CMP_BITS    = ((SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS) + 1;
    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [NIBBLE_BITS-1:0] t_nibble;
    typedef logic [SERVO_BITS-1:0]  t_servo;
    typedef logic [OFFSET_BITS-1:0] t_offset;

    // Register indexes on the configuration port.
    localparam logic [0:0] REG_HYST_OFFSET = 1'b0;

    localparam t_offset OFFSET_RESET = t_offset'(20);

    // Item kinds.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_STROBE = 1'b1;

    // Bus commands and replies.
    localparam t_nibble CMD_RESET   = 4'h0;
    localparam t_nibble CMD_GET     = 4'h2;
    localparam t_nibble CMD_TURN30  = 4'h3;
    localparam t_nibble CMD_TURN90  = 4'h4;
    localparam t_nibble CMD_TURN120 = 4'h5;
    localparam t_nibble REPLY_ACK   = 4'hE;

    // Servo requests.
    localparam t_servo SERVO_NONE = 2'd0;
    localparam t_servo SERVO_30   = 2'd1;
    localparam t_servo SERVO_90   = 2'd2;
    localparam t_servo SERVO_120  = 2'd3;

endpackage

FILE: rtl/core/lsnr_in_if.sv
// Input channel of the responder: one sample or one strobe edge per word.
interface lsnr_in_if;
    import lsnr_pkg::*;

    logic    valid;
    logic    ready;
    logic    operation;
    t_sample sample;
    logic    strobe_level;
    t_nibble bus_nibble;

    modport source (output valid, operation, sample, strobe_level, bus_nibble, input ready);
    modport sink   (input valid, operation, sample, strobe_level, bus_nibble, output ready);
endinterface

FILE: rtl/core/lsnr_out_if.sv
// Result channel of the responder: pin and bus levels after each input word.
interface lsnr_out_if;
    import lsnr_pkg::*;

    logic    valid;
    logic    ready;
    logic    led_pin;
    t_nibble bus_out;
    logic    bus_drive;
    t_servo  servo_code;

    modport source (output valid, led_pin, bus_out, bus_drive, servo_code, input ready);
    modport sink   (input valid, led_pin, bus_out, bus_drive, servo_code, output ready);
endinterface

FILE: rtl/core/light_sensor_nibble_responder.sv
// Light sensor nibble responder: LED hysteresis control and strobed nibble bus handshake.
//
// Usage. Words arrive on i_item: either a finished light sample (operation 0) or an
// edge on the bus strobe (operation 1) with its level and the bus nibble. Every word
// gives exactly one result word on o_result: LED pin level, the bus nibble and its
// drive enable, and a servo request that is raised only on the edge that runs a turn
// command. The user must write the hysteresis offset over the APB port at address 0 only
// while the block is idle; the block itself does not enforce it. A read returns it.
// Timing. A word is taken into an input register, worked on by compare and select
// logic and lands in the result register. One word is accepted every cycle while the
// receiver takes results; the single input register and single result register set
// that figure.
// Stalls. When the receiver holds ready low the result register keeps its word, the
// input register keeps the next one, and i_item.ready falls until space frees up.
// Reset. A synchronous active-low reset empties both registers, clears the tracking
// to minimum all ones and maximum zero, puts the handshake at its first step, releases
// the bus and restores the default offset.
module light_sensor_nibble_responder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lsnr_in_if.sink                         i_item,
    lsnr_out_if.source                      o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsnr_pkg::PADDR_BITS-1:0] paddr,
    input  logic [lsnr_pkg::PDATA_BITS-1:0] pwdata,
    output logic [lsnr_pkg::PDATA_BITS-1:0] prdata,
    output logic                            pready
);
    import lsnr_pkg::*;

    localparam logic [3:0] STEP_CMD      = 4'd0;
    localparam logic [3:0] STEP_EXEC     = 4'd1;
    localparam logic [3:0] STEP_WAIT2    = 4'd2;
    localparam logic [3:0] STEP_REPLY1   = 4'd3;
    localparam logic [3:0] STEP_WAIT4    = 4'd4;
    localparam logic [3:0] STEP_REPLY2   = 4'd5;
    localparam logic [3:0] STEP_WAIT6    = 4'd6;
    localparam logic [3:0] STEP_REPLY3   = 4'd7;
    localparam logic [3:0] STEP_WAIT8    = 4'd8;
    localparam logic [3:0] STEP_RELEASE  = 4'd9;

    // Configuration.
    t_offset r_offset;

    // Input register.
    logic    r_in_valid;
    logic    r_in_op;
    t_sample r_in_sample;
    logic    r_in_level;
    t_nibble r_in_nibble;

    // Block state.
    logic [3:0] r_step, n_step;
    t_nibble    r_cmd, n_cmd;
    t_sample    r_latest, n_latest;
    t_sample    r_max, n_max;
    t_sample    r_min, n_min;
    t_sample    r_mid, n_mid;
    logic       r_led, n_led;
    t_nibble    r_bus_val, n_bus_val;
    logic       r_bus_en, n_bus_en;
    t_servo     n_servo;

    // Result register.
    logic    r_out_valid;
    logic    r_out_led;
    t_nibble r_out_bus;
    logic    r_out_drive;
    t_servo  r_out_servo;

    logic advance;
    logic cfg_write;

    logic [CMP_BITS-1:0] mid_sum;
    logic [CMP_BITS-1:0] v_ext;
    logic [CMP_BITS-1:0] mid_ext;
    logic [CMP_BITS-1:0] off_ext;
    logic [15:0]         latest_ext;
    logic                is_get;

    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[PADDR_BITS-1:2] == REG_HYST_OFFSET);
    assign prdata    = (paddr[PADDR_BITS-1:2] == REG_HYST_OFFSET)
                       ? PDATA_BITS'(r_offset) : '0;

    assign latest_ext = 16'(r_latest);
    assign is_get     = (r_cmd == CMD_GET);

    always_comb begin
        n_step    = r_step;
        n_cmd     = r_cmd;
        n_latest  = r_latest;
        n_max     = r_max;
        n_min     = r_min;
        n_mid     = r_mid;
        n_led     = r_led;
        n_bus_val = r_bus_val;
        n_bus_en  = r_bus_en;
        n_servo   = SERVO_NONE;
        mid_sum   = '0;
        v_ext     = CMP_BITS'(r_in_sample);
        off_ext   = CMP_BITS'(r_offset);
        mid_ext   = '0;

        if (r_in_op == OP_SAMPLE) begin
            n_latest = r_in_sample;
            if (r_in_sample > r_max) begin
                n_max = r_in_sample;
            end
            if (r_in_sample < r_min) begin
                n_min = r_in_sample;
            end
            // Both bounds may move on one sample; the midpoint follows the final pair.
            mid_sum = CMP_BITS'(n_max) + CMP_BITS'(n_min);
            if ((r_in_sample > r_max) || (r_in_sample < r_min)) begin
                n_mid = t_sample'(mid_sum >> 1);
            end
            mid_ext = CMP_BITS'(n_mid);
            // Compared without subtraction so that a threshold below the offset cannot wrap.
            if (r_led) begin
                if ((v_ext + off_ext) < mid_ext) begin
                    n_led = 1'b0;
                end
            end else begin
                if (v_ext > (mid_ext + off_ext)) begin
                    n_led = 1'b1;
                end
            end
        end else if (r_in_level == !r_step[0]) begin
            case (r_step)
                STEP_CMD: begin
                    n_cmd  = r_in_nibble;
                    n_step = STEP_EXEC;
                end
                STEP_EXEC: begin
                    if (is_get) begin
                        n_bus_val = {2'b00, latest_ext[9:8]};
                    end else begin
                        case (r_cmd)
                            CMD_RESET: begin
                                n_max = '0;
                                n_min = '1;
                                n_mid = '0;
                            end
                            CMD_TURN30:  n_servo = SERVO_30;
                            CMD_TURN90:  n_servo = SERVO_90;
                            CMD_TURN120: n_servo = SERVO_120;
                            default:     n_servo = SERVO_NONE;
                        endcase
                        n_bus_val = REPLY_ACK;
                    end
                    n_bus_en = 1'b1;
                    n_step   = STEP_WAIT2;
                end
                STEP_REPLY1: begin
                    if (is_get) begin
                        n_bus_val = latest_ext[7:4];
                        n_step    = STEP_WAIT4;
                    end else begin
                        n_bus_en = 1'b0;
                        n_step   = STEP_CMD;
                    end
                end
                STEP_REPLY2: begin
                    n_bus_val = latest_ext[3:0];
                    n_step    = STEP_WAIT6;
                end
                STEP_REPLY3: begin
                    n_bus_val = REPLY_ACK;
                    n_step    = STEP_WAIT8;
                end
                STEP_RELEASE: begin
                    n_bus_en = 1'b0;
                    n_step   = STEP_CMD;
                end
                STEP_WAIT2, STEP_WAIT4, STEP_WAIT6, STEP_WAIT8: begin
                    n_step = r_step + 4'd1;
                end
                default: begin
                    n_step = STEP_CMD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RESET;
        end else if (cfg_write) begin
            r_offset <= pwdata[OFFSET_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_op     <= i_item.operation;
            r_in_sample <= i_item.sample;
            r_in_level  <= i_item.strobe_level;
            r_in_nibble <= i_item.bus_nibble;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STEP_CMD;
            r_cmd     <= CMD_RESET;
            r_latest  <= '0;
            r_max     <= '0;
            r_min     <= '1;
            r_mid     <= '0;
            r_led     <= 1'b0;
            r_bus_val <= '0;
            r_bus_en  <= 1'b0;
        end else if (advance) begin
            r_step    <= n_step;
            r_cmd     <= n_cmd;
            r_latest  <= n_latest;
            r_max     <= n_max;
            r_min     <= n_min;
            r_mid     <= n_mid;
            r_led     <= n_led;
            r_bus_val <= n_bus_val;
            r_bus_en  <= n_bus_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_led   <= n_led;
            r_out_bus   <= n_bus_en ? n_bus_val : '0;
            r_out_drive <= n_bus_en;
            r_out_servo <= n_servo;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.led_pin    = r_out_led;
    assign o_result.bus_out    = r_out_bus;
    assign o_result.bus_drive  = r_out_drive;
    assign o_result.servo_code = r_out_servo;

endmodule
